FILE: src/dabo_pkg.sv
// Shared types and constants of the dual-axis oscillator.
`default_nettype none
package dabo_pkg;

    localparam int unsigned OP_BITS  = 32;
    localparam int unsigned CNT_BITS = $clog2(OP_BITS);

    // Request to the shared serial multiply/divide unit.
    typedef struct packed {
        logic start;
        logic div;
    } t_mdu_req;

    localparam logic [2:0] WAVE_SINE  = 3'd0;
    localparam logic [2:0] WAVE_TRI   = 3'd1;
    localparam logic [2:0] WAVE_SAW   = 3'd2;
    localparam logic [2:0] WAVE_RAMP  = 3'd3;
    localparam logic [2:0] WAVE_PULSE = 3'd4;
    localparam logic [2:0] WAVE_NOISE = 3'd5;
    localparam logic [2:0] WAVE_HOLD  = 3'd6;
    localparam logic [2:0] WAVE_OFF   = 3'd7;

    localparam logic [7:0] REG_INC_X   = 8'd0;
    localparam logic [7:0] REG_INC_Y   = 8'd1;
    localparam logic [7:0] REG_OFF_Y   = 8'd2;
    localparam logic [7:0] REG_WAVE    = 8'd3;
    localparam logic [7:0] REG_WIDTH_X = 8'd4;
    localparam logic [7:0] REG_WIDTH_Y = 8'd5;
    localparam logic [7:0] REG_SYNC    = 8'd6;
    localparam logic [7:0] REG_BLANK   = 8'd7;

    localparam logic signed [35:0] V_ONE      = 36'sh1_0000_0000;
    localparam logic [31:0]        HALF_PI    = 32'd1686629713;
    localparam logic [31:0]        Q30        = 32'h4000_0000;
    localparam logic [15:0]        WIDTH_MIN  = 16'd1311;
    localparam logic [15:0]        WIDTH_MAX  = 16'd64225;
    localparam logic [15:0]        WIDTH_RST  = 16'd32768;
    localparam logic [31:0]        NOISE_SEED = 32'h1D87_2B41;
    localparam logic [31:0]        NOISE_TAPS = 32'h8020_0003;
    localparam logic [2:0]         SINE_LAST  = 3'd4;

endpackage
`default_nettype wire

FILE: src/dual_axis_blep_oscillator_unit.sv
// Top level of the dual-axis polyBLEP deflection oscillator.
//
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------------
// in      | in        | i_in_valid / o_in_ready    | i_sample_duration, i_frame_end
// out     | out       | o_out_valid / i_out_ready  | o_x_value, o_y_value, o_beam_on,
//         |           |                            | o_duration_out, o_frame_last
// cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request is worked at a time by a sequencer around one bit-serial multiply/
// divide unit. Triangle, noise, hold and silent use no arithmetic, saw and ramp use
// it only near an edge, pulse near either of its edges, and sine for eight
// multiplies and five divides.
// Reset is synchronous and active low; it restores state registers and the noise seed.
// A new request is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only at its final step.
`default_nettype none
module dual_axis_blep_oscillator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_sample_duration,
    input  wire logic               i_frame_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_x_value,
    output logic signed [15:0]      o_y_value,
    output logic                    o_beam_on,
    output logic [31:0]             o_duration_out,
    output logic                    o_frame_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_AXIS   = 4'd1;
    localparam logic [3:0] S_BLEP   = 4'd2;
    localparam logic [3:0] S_BDIV   = 4'd3;
    localparam logic [3:0] S_BMUL   = 4'd4;
    localparam logic [3:0] S_SIN_TH = 4'd5;
    localparam logic [3:0] S_SIN_T2 = 4'd6;
    localparam logic [3:0] S_SIN_M  = 4'd7;
    localparam logic [3:0] S_SIN_D  = 4'd8;
    localparam logic [3:0] S_SIN_S  = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;
    localparam logic [3:0] S_SYNC   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    // Round to nearest and saturate a Q32 value to a Q1.15 code.
    function automatic logic [15:0] to_code(input logic signed [35:0] x);
        logic signed [35:0] r;
        r = (x + 36'sd65536) >>> 17;
        if (r > 36'sd32767) begin
            return 16'h7FFF;
        end else if (r < -36'sd32768) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

    function automatic logic [31:0] sine_div(input logic [2:0] i);
        case (i)
            3'd0:    return 32'd110;
            3'd1:    return 32'd72;
            3'd2:    return 32'd42;
            3'd3:    return 32'd20;
            default: return 32'd6;
        endcase
    endfunction

    // Configuration
    logic [31:0] r_inc_x, r_inc_y, r_off_y;
    logic [5:0]  r_wave;
    logic [15:0] r_width_x, r_width_y;
    logic        r_sync, r_blank_en;

    // Oscillator state
    logic [31:0] r_phase_x, r_phase_y;
    logic [15:0] r_hold_x, r_hold_y;
    logic [31:0] r_lfsr;

    // Sequencer
    logic [3:0]  r_state, n_state;
    logic        r_ax;
    logic        r_bany;
    logic [31:0] r_p;
    logic signed [35:0] r_v;
    logic [31:0] r_th, r_t2;
    logic [2:0]  r_i;
    logic [1:0]  r_quad;
    logic        r_bsel, r_bneg, r_wx;
    logic [15:0] r_xcode, r_ycode;
    logic [31:0] r_dur;
    logic        r_frame;
    logic        r_out_valid;

    // Shared arithmetic
    dabo_pkg::t_mdu_req mdu_req;
    logic [31:0] mdu_a, mdu_b, mdu_c;
    logic [63:0] mdu_res;
    logic        mdu_done;

    dabo_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mdu_req),
        .i_op_a   (mdu_a),
        .i_op_b   (mdu_b),
        .i_op_c   (mdu_c),
        .o_result (mdu_res),
        .o_done   (mdu_done)
    );

    // Per-axis view
    logic [2:0]  cur_wave;
    logic [31:0] cur_inc;
    logic [15:0] cur_width, wclamp;
    logic [31:0] w32;
    logic [31:0] lfsr_nx;
    logic signed [35:0] noise_v;
    logic [9:0]  sin_idx;
    logic [10:0] sin_r;
    logic [32:0] tri_d, tri_abs;
    logic [31:0] bt;
    logic [32:0] bsum;
    logic        b_lo, b_hi, b_near;
    logic [31:0] bq, bqq;
    logic signed [35:0] bval;
    logic        b_sub;
    logic        b_more;
    logic [31:0] acc_new;
    logic [32:0] ph_next;
    logic [15:0] fin_code;
    logic        out_free;

    always_comb begin
        cur_wave  = r_ax ? r_wave[5:3] : r_wave[2:0];
        cur_inc   = r_ax ? r_inc_y : r_inc_x;
        cur_width = r_ax ? r_width_y : r_width_x;
        if (cur_width < dabo_pkg::WIDTH_MIN) begin
            wclamp = dabo_pkg::WIDTH_MIN;
        end else if (cur_width > dabo_pkg::WIDTH_MAX) begin
            wclamp = dabo_pkg::WIDTH_MAX;
        end else begin
            wclamp = cur_width;
        end
        w32 = {wclamp, 16'd0};

        lfsr_nx = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? dabo_pkg::NOISE_TAPS : 32'd0);
        noise_v = $signed({3'b000, lfsr_nx, 1'b0}) - dabo_pkg::V_ONE;

        // Quarter-wave fold of the table index
        sin_idx = r_p[31:22];
        sin_r   = {1'b0, sin_idx[7:0], 2'b00};
        if (sin_idx[8]) begin
            sin_r = 11'd1024 - sin_r;
        end

        tri_d   = {1'b0, r_p} - 33'h0_8000_0000;
        tri_abs = tri_d[32] ? (33'd0 - tri_d) : tri_d;

        // Edge test for the current correction term
        bt     = r_bsel ? (r_p - w32) : r_p;
        bsum   = {1'b0, bt} + {1'b0, cur_inc};
        b_lo   = bt < cur_inc;
        b_hi   = bsum > 33'h1_0000_0000;
        b_near = b_lo || b_hi;

        bq  = r_th;
        bqq = mdu_res[63:32];
        if (r_bneg) begin
            bval = $signed({4'b0000, bqq}) - $signed({3'b000, bq, 1'b0}) + dabo_pkg::V_ONE;
        end else begin
            bval = $signed({3'b000, bq, 1'b0}) - $signed({4'b0000, bqq}) - dabo_pkg::V_ONE;
        end
        b_sub  = (cur_wave == dabo_pkg::WAVE_SAW) ||
                 ((cur_wave == dabo_pkg::WAVE_PULSE) && !r_bsel);
        b_more = (cur_wave == dabo_pkg::WAVE_PULSE) && !r_bsel;

        acc_new = dabo_pkg::Q30 - mdu_res[31:0];

        ph_next  = {1'b0, (r_ax ? r_phase_y : r_phase_x)} + {1'b0, cur_inc};
        fin_code = (cur_wave == dabo_pkg::WAVE_HOLD) ? (r_ax ? r_hold_y : r_hold_x)
                                                     : to_code(r_v);
        out_free = !r_out_valid || i_out_ready;
    end

    // Operation requests to the multiply/divide unit
    always_comb begin
        mdu_req = '0;
        mdu_a   = '0;
        mdu_b   = '0;
        mdu_c   = '0;
        case (r_state)
            S_AXIS: begin
                if (cur_wave == dabo_pkg::WAVE_SINE) begin
                    mdu_req.start = 1'b1;
                    mdu_a = dabo_pkg::HALF_PI;
                    mdu_b = {21'd0, sin_r};
                end
            end
            S_BLEP: begin
                if (b_near) begin
                    mdu_req = '{start: 1'b1, div: 1'b1};
                    mdu_a = b_lo ? bt : (32'd0 - bt);
                    mdu_b = cur_inc;
                end
            end
            S_BDIV: begin
                if (mdu_done) begin
                    mdu_req.start = 1'b1;
                    mdu_a = mdu_res[31:0];
                    mdu_b = mdu_res[31:0];
                end
            end
            S_SIN_TH: begin
                if (mdu_done) begin
                    mdu_req.start = 1'b1;
                    mdu_a = mdu_res[41:10];
                    mdu_b = mdu_res[41:10];
                end
            end
            S_SIN_T2: begin
                if (mdu_done) begin
                    mdu_req.start = 1'b1;
                    mdu_a = mdu_res[61:30];
                    mdu_b = dabo_pkg::Q30;
                end
            end
            S_SIN_M: begin
                if (mdu_done) begin
                    mdu_req = '{start: 1'b1, div: 1'b1};
                    mdu_c = mdu_res[61:30];
                    mdu_b = sine_div(r_i);
                end
            end
            S_SIN_D: begin
                if (mdu_done) begin
                    mdu_req.start = 1'b1;
                    mdu_a = (r_i == dabo_pkg::SINE_LAST) ? r_th : r_t2;
                    mdu_b = acc_new;
                end
            end
            default: begin
                mdu_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_AXIS;
            end
            S_AXIS: begin
                case (cur_wave) inside
                    dabo_pkg::WAVE_SINE:  n_state = S_SIN_TH;
                    dabo_pkg::WAVE_SAW, dabo_pkg::WAVE_RAMP,
                    dabo_pkg::WAVE_PULSE: n_state = S_BLEP;
                    default:              n_state = S_FINISH;
                endcase
            end
            S_BLEP: begin
                if (b_near) begin
                    n_state = S_BDIV;
                end else if (!b_more) begin
                    n_state = S_FINISH;
                end
            end
            S_BDIV:   if (mdu_done) n_state = S_BMUL;
            S_BMUL:   if (mdu_done) n_state = b_more ? S_BLEP : S_FINISH;
            S_SIN_TH: if (mdu_done) n_state = S_SIN_T2;
            S_SIN_T2: if (mdu_done) n_state = S_SIN_M;
            S_SIN_M:  if (mdu_done) n_state = S_SIN_D;
            S_SIN_D: begin
                if (mdu_done) n_state = (r_i == dabo_pkg::SINE_LAST) ? S_SIN_S : S_SIN_M;
            end
            S_SIN_S:  if (mdu_done) n_state = S_FINISH;
            S_FINISH: n_state = r_ax ? S_OUT : S_SYNC;
            S_SYNC:   n_state = S_AXIS;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control, configuration and oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inc_x     <= '0;
            r_inc_y     <= '0;
            r_off_y     <= '0;
            r_wave      <= '0;
            r_width_x   <= dabo_pkg::WIDTH_RST;
            r_width_y   <= dabo_pkg::WIDTH_RST;
            r_sync      <= 1'b0;
            r_blank_en  <= 1'b0;
            r_phase_x   <= '0;
            r_phase_y   <= '0;
            r_hold_x    <= '0;
            r_hold_y    <= '0;
            r_lfsr      <= dabo_pkg::NOISE_SEED;
            r_ax        <= 1'b0;
            r_bany      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dabo_pkg::REG_INC_X:   r_inc_x    <= i_cfg_data;
                    dabo_pkg::REG_INC_Y:   r_inc_y    <= i_cfg_data;
                    dabo_pkg::REG_OFF_Y:   r_off_y    <= i_cfg_data;
                    dabo_pkg::REG_WAVE:    r_wave     <= i_cfg_data[5:0];
                    dabo_pkg::REG_WIDTH_X: r_width_x  <= i_cfg_data[15:0];
                    dabo_pkg::REG_WIDTH_Y: r_width_y  <= i_cfg_data[15:0];
                    dabo_pkg::REG_SYNC:    r_sync     <= i_cfg_data[0];
                    dabo_pkg::REG_BLANK:   r_blank_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Load a new result, else drop the one just taken
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ax   <= 1'b0;
                        r_bany <= 1'b0;
                    end
                end
                S_AXIS: begin
                    if (cur_wave == dabo_pkg::WAVE_NOISE) r_lfsr <= lfsr_nx;
                end
                S_BLEP: begin
                    if (b_near) r_bany <= 1'b1;
                end
                S_FINISH: begin
                    // Advance the axis; in hold mode a wrap refreshes its held sample
                    if (r_ax) r_phase_y <= ph_next[31:0];
                    else      r_phase_x <= ph_next[31:0];
                    if (ph_next[32] && (cur_wave == dabo_pkg::WAVE_HOLD)) begin
                        r_lfsr <= lfsr_nx;
                        if (r_ax) r_hold_y <= to_code(noise_v);
                        else      r_hold_x <= to_code(noise_v);
                    end
                end
                S_SYNC: begin
                    // Hard sync restarts Y before it is read
                    r_ax <= 1'b1;
                    if (r_sync && r_wx) begin
                        r_phase_y <= '0;
                        if (r_wave[5:3] == dabo_pkg::WAVE_HOLD) begin
                            r_lfsr   <= lfsr_nx;
                            r_hold_y <= to_code(noise_v);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_dur   <= i_sample_duration;
                    r_frame <= i_frame_end;
                    r_p     <= r_phase_x;
                end
            end
            S_AXIS: begin
                r_bsel <= 1'b0;
                r_quad <= sin_idx[9:8];
                case (cur_wave)
                    dabo_pkg::WAVE_TRI:
                        r_v <= dabo_pkg::V_ONE - $signed({1'b0, tri_abs, 2'b00});
                    dabo_pkg::WAVE_SAW:
                        r_v <= $signed({3'b000, r_p, 1'b0}) - dabo_pkg::V_ONE;
                    dabo_pkg::WAVE_RAMP:
                        r_v <= dabo_pkg::V_ONE - $signed({3'b000, r_p, 1'b0});
                    dabo_pkg::WAVE_PULSE:
                        r_v <= (r_p < w32) ? dabo_pkg::V_ONE : -dabo_pkg::V_ONE;
                    dabo_pkg::WAVE_NOISE:
                        r_v <= noise_v;
                    default:
                        r_v <= '0;
                endcase
            end
            S_BLEP: begin
                r_bneg <= !b_lo;
                if (!b_near && b_more) r_bsel <= 1'b1;
            end
            S_BDIV: begin
                if (mdu_done) r_th <= mdu_res[31:0];
            end
            S_BMUL: begin
                if (mdu_done) begin
                    r_v <= b_sub ? (r_v - bval) : (r_v + bval);
                    if (b_more) r_bsel <= 1'b1;
                end
            end
            S_SIN_TH: begin
                if (mdu_done) r_th <= mdu_res[41:10];
            end
            S_SIN_T2: begin
                if (mdu_done) begin
                    r_t2 <= mdu_res[61:30];
                    r_i  <= '0;
                end
            end
            S_SIN_D: begin
                if (mdu_done) r_i <= r_i + 1'b1;
            end
            S_SIN_S: begin
                if (mdu_done) begin
                    r_v <= r_quad[1] ? -$signed({2'b00, mdu_res[61:30], 2'b00})
                                     :  $signed({2'b00, mdu_res[61:30], 2'b00});
                end
            end
            S_FINISH: begin
                if (r_ax) begin
                    r_ycode <= fin_code;
                end else begin
                    r_xcode <= fin_code;
                    r_wx    <= ph_next[32];
                end
            end
            S_SYNC: begin
                r_p <= ((r_sync && r_wx) ? 32'd0 : r_phase_y) + r_off_y;
            end
            S_OUT: begin
                if (out_free) begin
                    o_x_value      <= r_xcode;
                    o_y_value      <= r_ycode;
                    o_beam_on      <= !(r_blank_en && r_bany);
                    o_duration_out <= r_dur;
                    o_frame_last   <= r_frame;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // The blanking flag is only raised by an edge test
    a_bany_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_bany) |-> $past(r_state) == S_BLEP)
        else $error("blanking flag set outside edge test");

    // A finished arithmetic operation always finds the sequencer waiting for it
    a_mdu_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_done |-> (r_state == S_BDIV || r_state == S_BMUL || r_state == S_SIN_TH ||
                      r_state == S_SIN_T2 || r_state == S_SIN_M || r_state == S_SIN_D ||
                      r_state == S_SIN_S))
        else $error("arithmetic result dropped");

    // Y is evaluated only after the sync step
    a_axis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ax) |-> $past(r_state) == S_SYNC)
        else $error("Y axis entered without sync step");

endmodule
`default_nettype wire

FILE: src/dabo_mdu.sv
// Shared bit-serial unsigned multiplier and restoring divider.
`default_nettype none
module dabo_mdu (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dabo_pkg::t_mdu_req  i_req,
    input  wire logic [31:0]         i_op_a,
    input  wire logic [31:0]         i_op_b,
    input  wire logic [31:0]         i_op_c,
    output logic [63:0]              o_result,
    output logic                     o_done
);
    logic [63:0] r_prod;
    logic [31:0] r_b;
    logic [dabo_pkg::CNT_BITS-1:0] r_cnt;
    logic r_busy;
    logic r_div;
    logic r_done;

    logic [32:0] mul_sum;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_rem;

    always_comb begin
        mul_sum = {1'b0, r_prod[63:32]} + (r_prod[0] ? {1'b0, r_b} : 33'd0);
        div_sh  = {r_prod[63:32], r_prod[31]};
        div_ge  = div_sh >= {1'b0, r_b};
        div_rem = div_ge ? (div_sh - {1'b0, r_b}) : div_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == dabo_pkg::CNT_BITS'(dabo_pkg::OP_BITS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dabo_pkg::CNT_BITS'(dabo_pkg::OP_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // One product bit or one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div  <= i_req.div;
            r_b    <= i_req.div ? i_op_b : i_op_a;
            r_prod <= i_req.div ? {i_op_a, i_op_c} : {32'd0, i_op_b};
        end else if (r_busy) begin
            if (r_div) begin
                r_prod <= {div_rem[31:0], r_prod[30:0], div_ge};
            end else begin
                r_prod <= {mul_sum, r_prod[31:1]};
            end
        end
    end

    assign o_result = r_prod;
    assign o_done   = r_done;
endmodule
`default_nettype wire

FILE: test/dual_axis_blep_oscillator_unit_tb.sv
// Testbench for the dual-axis oscillator: predicts every sample and checks each field.
`default_nettype none
module dual_axis_blep_oscillator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One cycle in units of 2^-32.
    localparam longint signed ONE_CYC = 64'sd4294967296;
    localparam logic [63:0]   ONE_U   = 64'h1_0000_0000;
    // An index past the register map; the block must ignore it.
    localparam logic [7:0]    REG_NONE = 8'd200;
    // Settle this long before touching registers; it outlasts the longest request.
    localparam int            SETTLE = 1000;

    typedef struct {
        logic [31:0] dur;
        logic        last;
    } t_tick;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        beam;
        logic [31:0] dur;
        logic        last;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [31:0]        i_sample_duration = '0;
    logic               i_frame_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_x_value;
    logic signed [15:0] o_y_value;
    logic               o_beam_on;
    logic [31:0]        o_duration_out;
    logic               o_frame_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    dual_axis_blep_oscillator_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_duration(i_sample_duration),
        .i_frame_end(i_frame_end),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_x_value(o_x_value),
        .o_y_value(o_y_value),
        .o_beam_on(o_beam_on),
        .o_duration_out(o_duration_out),
        .o_frame_last(o_frame_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the registers and state.
    logic [31:0] inc_x, inc_y, offset_y;
    logic [5:0]  wave_sel;
    logic [15:0] duty_x, duty_y;
    logic        sync_on, blank_on;
    logic [31:0] acc_x, acc_y;
    logic [15:0] held_x, held_y;
    logic [31:0] lfsr;

    t_tick   tick_q[$];
    t_sample sample_q[$];
    int      errors = 0;
    bit      quiet = 0;
    bit      in_taken = 0;
    int      in_gap = 0;
    int      out_stall = 0;

    function automatic void reset_predictor();
        inc_x = '0;
        inc_y = '0;
        offset_y = '0;
        wave_sel = '0;
        duty_x = dabo_pkg::WIDTH_RST;
        duty_y = dabo_pkg::WIDTH_RST;
        sync_on = 1'b0;
        blank_on = 1'b0;
        acc_x = '0;
        acc_y = '0;
        held_x = '0;
        held_y = '0;
        lfsr = dabo_pkg::NOISE_SEED;
    endfunction

    function automatic void apply_reg(input logic [7:0] idx, input logic [31:0] data);
        case (idx)
            dabo_pkg::REG_INC_X:   inc_x = data;
            dabo_pkg::REG_INC_Y:   inc_y = data;
            dabo_pkg::REG_OFF_Y:   offset_y = data;
            dabo_pkg::REG_WAVE:    wave_sel = data[5:0];
            dabo_pkg::REG_WIDTH_X: duty_x = data[15:0];
            dabo_pkg::REG_WIDTH_Y: duty_y = data[15:0];
            dabo_pkg::REG_SYNC:    sync_on = data[0];
            dabo_pkg::REG_BLANK:   blank_on = data[0];
            default: ;
        endcase
    endfunction

    // Step the Galois LFSR and map it to -1..+1.
    function automatic longint signed draw_noise();
        logic lsb;
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ dabo_pkg::NOISE_TAPS;
        return $signed({32'b0, lfsr}) * 2 - ONE_CYC;
    endfunction

    // Round to nearest Q1.15 and saturate.
    function automatic logic [15:0] to_code(input longint signed v);
        longint signed c;
        c = ((v + 8 * ONE_CYC + 65536) >>> 17) - (64'sd8 <<< 15);
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[15:0];
    endfunction

    function automatic longint signed blep(input logic [31:0] t, input logic [31:0] dt);
        logic [63:0] u, uu;
        if (dt == 0) return 0;
        if (t < dt) begin
            u = {t, 32'b0} / {32'b0, dt};
            uu = (u * u) >> 32;
            return $signed(2 * u) - $signed(uu) - ONE_CYC;
        end
        if ({32'b0, t} > ONE_U - {32'b0, dt}) begin
            u = ((ONE_U - {32'b0, t}) << 32) / {32'b0, dt};
            uu = (u * u) >> 32;
            return $signed(uu) - $signed(2 * u) + ONE_CYC;
        end
        return 0;
    endfunction

    function automatic bit near_edge(input logic [31:0] t, input logic [31:0] dt);
        return (t < dt) || ({32'b0, t} > ONE_U - {32'b0, dt});
    endfunction

    // Quarter-wave Taylor sine at a 1024-entry phase grid.
    function automatic longint signed sine_value(input logic [31:0] p);
        int          divs[5];
        logic [63:0] quad, r, th, t2, acc, s;
        divs = '{110, 72, 42, 20, 6};
        quad = {62'b0, p[31:30]};
        r = {54'b0, p[29:22], 2'b0};
        if (quad[0]) r = 1024 - r;
        th = {32'b0, dabo_pkg::HALF_PI} * r / 1024;
        t2 = (th * th) >> 30;
        acc = {32'b0, dabo_pkg::Q30};
        for (int i = 0; i < 5; i++)
            acc = {32'b0, dabo_pkg::Q30} - ((t2 * acc) >> 30) / divs[i];
        s = (th * acc) >> 30;
        return quad[1] ? -$signed(s << 2) : $signed(s << 2);
    endfunction

    // Evaluate one axis at its read phase, then advance it.
    function automatic logic [15:0] axis_sample(inout logic [31:0] acc, input logic [31:0] inc,
                                                input logic [2:0] wave, input logic [15:0] duty,
                                                input logic [31:0] offs, inout logic [15:0] held,
                                                output bit blank, output bit wrapped);
        logic [31:0]    p, w, sh;
        longint signed  v, d;
        logic [15:0]    code;
        logic [32:0]    nxt;
        p = acc + offs;
        v = 0;
        blank = 0;
        case (wave)
            dabo_pkg::WAVE_SINE: v = sine_value(p);
            dabo_pkg::WAVE_TRI: begin
                d = $signed({32'b0, p}) - 64'sd2147483648;
                if (d < 0) d = -d;
                v = ONE_CYC - 4 * d;
            end
            dabo_pkg::WAVE_SAW: begin
                v = 2 * $signed({32'b0, p}) - ONE_CYC - blep(p, inc);
                blank = near_edge(p, inc);
            end
            dabo_pkg::WAVE_RAMP: begin
                v = ONE_CYC - 2 * $signed({32'b0, p}) + blep(p, inc);
                blank = near_edge(p, inc);
            end
            dabo_pkg::WAVE_PULSE: begin
                w = {16'b0, duty < dabo_pkg::WIDTH_MIN ? dabo_pkg::WIDTH_MIN :
                            (duty > dabo_pkg::WIDTH_MAX ? dabo_pkg::WIDTH_MAX : duty)};
                w = w << 16;
                sh = p - w;
                v = (p < w ? ONE_CYC : -ONE_CYC) - blep(p, inc) + blep(sh, inc);
                blank = near_edge(p, inc) || near_edge(sh, inc);
            end
            dabo_pkg::WAVE_NOISE: v = draw_noise();
            default: v = 0;
        endcase
        code = (wave == dabo_pkg::WAVE_HOLD) ? held : to_code(v);
        nxt = {1'b0, acc} + {1'b0, inc};
        wrapped = nxt[32];
        acc = nxt[31:0];
        if (wrapped && wave == dabo_pkg::WAVE_HOLD) held = to_code(draw_noise());
        return code;
    endfunction

    function automatic t_sample predict_sample(input t_tick tk);
        t_sample e;
        bit      bx, by, wx, wy;
        e.x = axis_sample(acc_x, inc_x, wave_sel[2:0], duty_x, 32'b0, held_x, bx, wx);
        if (sync_on && wx) begin
            acc_y = '0;
            if (wave_sel[5:3] == dabo_pkg::WAVE_HOLD) held_y = to_code(draw_noise());
        end
        e.y = axis_sample(acc_y, inc_y, wave_sel[5:3], duty_y, offset_y, held_y, by, wy);
        e.beam = !(blank_on && (bx || by));
        e.dur = tk.dur;
        e.last = tk.last;
        return e;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
        end
    endfunction

    // Driver: present pending ticks with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_sample_duration <= tick_q[0].dur;
                i_frame_end <= tick_q[0].last;
                if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Accepted request: predict its sample now.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sample_q.push_back(predict_sample(tick_q.pop_front()));
            in_taken = 1;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_ready <= i_rst_n;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 15);
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_sample e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sample_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual x=%h y=%h", $realtime,
                         o_x_value, o_y_value);
            end else begin
                e = sample_q.pop_front();
                check_field("x_value", {16'b0, e.x}, {16'b0, o_x_value});
                check_field("y_value", {16'b0, e.y}, {16'b0, o_y_value});
                check_field("beam_on", {31'b0, e.beam}, {31'b0, o_beam_on});
                check_field("duration_out", e.dur, o_duration_out);
                check_field("frame_last", {31'b0, e.last}, {31'b0, o_frame_last});
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every sample is back and the block has gone quiet.
    task automatic drain();
        wait (tick_q.size() == 0 && sample_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_inc();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom >> $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [31:0] pick_duty();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [31:0] ix, input logic [31:0] iy, input logic [31:0] off,
                             input logic [31:0] wv, input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] sy, input logic [31:0] bl, input int n);
        t_tick tk;
        write_reg(dabo_pkg::REG_INC_X, ix);
        write_reg(dabo_pkg::REG_INC_Y, iy);
        write_reg(dabo_pkg::REG_OFF_Y, off);
        write_reg(dabo_pkg::REG_WAVE, wv);
        write_reg(dabo_pkg::REG_WIDTH_X, dx);
        write_reg(dabo_pkg::REG_WIDTH_Y, dy);
        write_reg(dabo_pkg::REG_SYNC, sy);
        write_reg(dabo_pkg::REG_BLANK, bl);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: tk.dur = 32'h0;
                1: tk.dur = 32'hFFFF_FFFF;
                default: tk.dur = $urandom;
            endcase
            tk.last = ($urandom_range(0, 7) == 0);
            tick_q.push_back(tk);
        end
        drain();
    endtask

    initial begin
        t_tick tk;
        reset_predictor();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: sine on both axes, frozen phase.
        tk.dur = 32'hFFFF_FFFF;
        tk.last = 1'b1;
        tick_q.push_back(tk);
        tk.dur = 32'h0;
        tk.last = 1'b0;
        tick_q.push_back(tk);
        drain();

        // Saw and ramp with edge correction and blanking.
        run_phase(32'h1000_0000, 32'h0C00_0000, 32'h0,
                  {26'b0, dabo_pkg::WAVE_RAMP, dabo_pkg::WAVE_SAW},
                  32'h8000, 32'h8000, 32'h0, 32'h1, 3);
        // Pulse with duty clamped at both ends, Y step above one half.
        run_phase(32'h2000_0000, 32'hC000_0000, 32'h1234_5678,
                  {26'b0, dabo_pkg::WAVE_PULSE, dabo_pkg::WAVE_PULSE},
                  32'h0, 32'hFFFF, 32'h0, 32'h1, 3);
        // Triangle read half a cycle ahead saturates at +1.
        run_phase(32'h0123_4567, 32'h0, 32'h8000_0000,
                  {26'b0, dabo_pkg::WAVE_TRI, dabo_pkg::WAVE_SINE},
                  32'h8000, 32'h8000, 32'h0, 32'h0, 3);
        // Noise on X, hold on Y restarted by hard sync.
        run_phase(32'h8000_0000, 32'h4000_0000, 32'h0,
                  {26'b0, dabo_pkg::WAVE_HOLD, dabo_pkg::WAVE_NOISE},
                  32'h8000, 32'h8000, 32'h1, 32'h1, 4);
        // Hold on X at the largest step, silent Y.
        run_phase(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  {26'b0, dabo_pkg::WAVE_OFF, dabo_pkg::WAVE_HOLD},
                  32'h1, 32'hFFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 3);
        // Upper register bits and an unmapped index must be ignored.
        write_reg(REG_NONE, $urandom);
        run_phase(32'h0400_0000, 32'h0, 32'h0,
                  {26'h3FF_FFFF, dabo_pkg::WAVE_OFF, dabo_pkg::WAVE_SAW},
                  32'hFFFF_0800, 32'h0001_8000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 3);

        // Random settings in long phases; the last runs without idling.
        for (int ph = 0; ph < 22; ph++) begin
            if (ph == 21) quiet = 1;
            if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom);
            run_phase(pick_inc(), pick_inc(),
                      $urandom_range(0, 1) ? $urandom : 32'h0,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63),
                      pick_duty(), pick_duty(), $urandom, $urandom, 50);
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
